[sv/tfcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Thermal false-color mapper package
// Shared constants, types and the iron palette table.
// ---------------------------------------------------------------------------
package tfcm_pkg;

  localparam int TEMP_FRAC_BITS = 4;
  localparam int TEMP_W         = 16;
  localparam int BOUND_W        = 11;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int COLOR_W        = 8;
  localparam int IRON_SIZE      = 119;
  localparam int RAINBOW_SIZE   = 1021;
  localparam int RAMP_WIDTH     = 255;
  localparam int MAX_DEGREES    = 80;
  localparam int BOUND_TOP      = MAX_DEGREES * (1 << TEMP_FRAC_BITS);
  // Quotient register width (holds up to RAINBOW_SIZE - 1).
  localparam int IDX_W          = 10;
  // Numerator 2*d*(S-1)+span < 2^22.
  localparam int NUM_W          = 22;
  localparam int DEN_W          = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SELECT = 2'd2;

  localparam logic PAL_IRON    = 1'b0;
  localparam logic PAL_RAINBOW = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;

  // Iron palette, packed as {red, green, blue}.
  function automatic rgb_t iron_lookup(input logic [6:0] k);
    rgb_t c;
    case (k)
      7'd0: c = '{8'd0,8'd0,8'd0};       7'd1: c = '{8'd0,8'd0,8'd36};
      7'd2: c = '{8'd0,8'd0,8'd51};      7'd3: c = '{8'd0,8'd0,8'd66};
      7'd4: c = '{8'd0,8'd0,8'd81};      7'd5: c = '{8'd2,8'd0,8'd90};
      7'd6: c = '{8'd4,8'd0,8'd99};      7'd7: c = '{8'd7,8'd0,8'd106};
      7'd8: c = '{8'd11,8'd0,8'd115};    7'd9: c = '{8'd14,8'd0,8'd119};
      7'd10: c = '{8'd20,8'd0,8'd123};   7'd11: c = '{8'd27,8'd0,8'd128};
      7'd12: c = '{8'd33,8'd0,8'd133};   7'd13: c = '{8'd41,8'd0,8'd137};
      7'd14: c = '{8'd48,8'd0,8'd140};   7'd15: c = '{8'd55,8'd0,8'd143};
      7'd16: c = '{8'd61,8'd0,8'd146};   7'd17: c = '{8'd66,8'd0,8'd149};
      7'd18: c = '{8'd72,8'd0,8'd150};   7'd19: c = '{8'd78,8'd0,8'd151};
      7'd20: c = '{8'd84,8'd0,8'd152};   7'd21: c = '{8'd91,8'd0,8'd153};
      7'd22: c = '{8'd97,8'd0,8'd155};   7'd23: c = '{8'd104,8'd0,8'd155};
      7'd24: c = '{8'd110,8'd0,8'd156};  7'd25: c = '{8'd115,8'd0,8'd157};
      7'd26: c = '{8'd122,8'd0,8'd157};  7'd27: c = '{8'd128,8'd0,8'd157};
      7'd28: c = '{8'd134,8'd0,8'd157};  7'd29: c = '{8'd139,8'd0,8'd157};
      7'd30: c = '{8'd146,8'd0,8'd156};  7'd31: c = '{8'd152,8'd0,8'd155};
      7'd32: c = '{8'd157,8'd0,8'd155};  7'd33: c = '{8'd162,8'd0,8'd155};
      7'd34: c = '{8'd167,8'd0,8'd154};  7'd35: c = '{8'd171,8'd0,8'd153};
      7'd36: c = '{8'd175,8'd1,8'd152};  7'd37: c = '{8'd178,8'd1,8'd151};
      7'd38: c = '{8'd182,8'd2,8'd149};  7'd39: c = '{8'd185,8'd4,8'd149};
      7'd40: c = '{8'd188,8'd5,8'd147};  7'd41: c = '{8'd191,8'd6,8'd146};
      7'd42: c = '{8'd193,8'd8,8'd144};  7'd43: c = '{8'd195,8'd11,8'd142};
      7'd44: c = '{8'd198,8'd13,8'd139}; 7'd45: c = '{8'd201,8'd17,8'd135};
      7'd46: c = '{8'd203,8'd20,8'd132}; 7'd47: c = '{8'd206,8'd23,8'd127};
      7'd48: c = '{8'd208,8'd26,8'd121}; 7'd49: c = '{8'd210,8'd29,8'd116};
      7'd50: c = '{8'd212,8'd33,8'd111}; 7'd51: c = '{8'd214,8'd37,8'd103};
      7'd52: c = '{8'd217,8'd41,8'd97};  7'd53: c = '{8'd219,8'd46,8'd89};
      7'd54: c = '{8'd221,8'd49,8'd78};  7'd55: c = '{8'd223,8'd53,8'd66};
      7'd56: c = '{8'd224,8'd56,8'd54};  7'd57: c = '{8'd226,8'd60,8'd42};
      7'd58: c = '{8'd228,8'd64,8'd30};  7'd59: c = '{8'd229,8'd68,8'd25};
      7'd60: c = '{8'd231,8'd72,8'd20};  7'd61: c = '{8'd232,8'd76,8'd16};
      7'd62: c = '{8'd234,8'd78,8'd12};  7'd63: c = '{8'd235,8'd82,8'd10};
      7'd64: c = '{8'd236,8'd86,8'd8};   7'd65: c = '{8'd237,8'd90,8'd7};
      7'd66: c = '{8'd238,8'd93,8'd5};   7'd67: c = '{8'd239,8'd96,8'd4};
      7'd68: c = '{8'd240,8'd100,8'd3};  7'd69: c = '{8'd241,8'd103,8'd3};
      7'd70: c = '{8'd241,8'd106,8'd2};  7'd71: c = '{8'd242,8'd109,8'd1};
      7'd72: c = '{8'd243,8'd113,8'd1};  7'd73: c = '{8'd244,8'd116,8'd0};
      7'd74: c = '{8'd244,8'd120,8'd0};  7'd75: c = '{8'd245,8'd125,8'd0};
      7'd76: c = '{8'd246,8'd129,8'd0};  7'd77: c = '{8'd247,8'd133,8'd0};
      7'd78: c = '{8'd248,8'd136,8'd0};  7'd79: c = '{8'd248,8'd139,8'd0};
      7'd80: c = '{8'd249,8'd142,8'd0};  7'd81: c = '{8'd249,8'd145,8'd0};
      7'd82: c = '{8'd250,8'd149,8'd0};  7'd83: c = '{8'd251,8'd154,8'd0};
      7'd84: c = '{8'd252,8'd159,8'd0};  7'd85: c = '{8'd253,8'd163,8'd0};
      7'd86: c = '{8'd253,8'd168,8'd0};  7'd87: c = '{8'd253,8'd172,8'd0};
      7'd88: c = '{8'd254,8'd176,8'd0};  7'd89: c = '{8'd254,8'd179,8'd0};
      7'd90: c = '{8'd254,8'd184,8'd0};  7'd91: c = '{8'd254,8'd187,8'd0};
      7'd92: c = '{8'd254,8'd191,8'd0};  7'd93: c = '{8'd254,8'd195,8'd0};
      7'd94: c = '{8'd254,8'd199,8'd0};  7'd95: c = '{8'd254,8'd202,8'd1};
      7'd96: c = '{8'd254,8'd205,8'd2};  7'd97: c = '{8'd254,8'd208,8'd5};
      7'd98: c = '{8'd254,8'd212,8'd9};  7'd99: c = '{8'd254,8'd216,8'd12};
      7'd100: c = '{8'd255,8'd219,8'd15};  7'd101: c = '{8'd255,8'd221,8'd23};
      7'd102: c = '{8'd255,8'd224,8'd32};  7'd103: c = '{8'd255,8'd227,8'd39};
      7'd104: c = '{8'd255,8'd229,8'd50};  7'd105: c = '{8'd255,8'd232,8'd63};
      7'd106: c = '{8'd255,8'd235,8'd75};  7'd107: c = '{8'd255,8'd238,8'd88};
      7'd108: c = '{8'd255,8'd239,8'd102}; 7'd109: c = '{8'd255,8'd241,8'd116};
      7'd110: c = '{8'd255,8'd242,8'd134}; 7'd111: c = '{8'd255,8'd244,8'd149};
      7'd112: c = '{8'd255,8'd245,8'd164}; 7'd113: c = '{8'd255,8'd247,8'd179};
      7'd114: c = '{8'd255,8'd248,8'd192}; 7'd115: c = '{8'd255,8'd249,8'd203};
      7'd116: c = '{8'd255,8'd251,8'd216}; 7'd117: c = '{8'd255,8'd253,8'd228};
      default: c = '{8'd255,8'd254,8'd239};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/tfcm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Thermal mapper stream channels
// Valid/ready channels for temperature samples and RGB pixels.
// ---------------------------------------------------------------------------
interface tfcm_temp_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfcm_pkg::TEMP_W-1:0]  temp_in;
  modport source (output valid, output temp_in, input ready);
  modport sink   (input valid, input temp_in, output ready);
endinterface

interface tfcm_rgb_if;
  logic                    valid;
  logic                    ready;
  tfcm_pkg::color_t        red;
  tfcm_pkg::color_t        green;
  tfcm_pkg::color_t        blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

[sv/tfcm_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Thermal mapper pipelined divider
// Restoring divider, one quotient bit per stage, with valid bits and a
// shared advance enable so a stall holds every stage in place.
// ---------------------------------------------------------------------------
module tfcm_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          in_vld,
  input  wire logic [tfcm_pkg::NUM_W-1:0]    in_num,
  input  wire logic [tfcm_pkg::DEN_W-1:0]    in_den,
  input  wire logic                          in_pal,
  output logic                               out_vld,
  output logic [tfcm_pkg::IDX_W-1:0]         out_quo,
  output logic                               out_pal
);
  localparam int N  = tfcm_pkg::IDX_W;
  localparam int NW = tfcm_pkg::NUM_W;
  localparam int DW = tfcm_pkg::DEN_W;

  // Stage s holds the partial remainder after quotient bit N-s is decided.
  logic          vld_r [N+1];
  logic [NW-1:0] rem_r [N+1];
  logic [DW-1:0] den_r [N+1];
  logic [N-1:0]  quo_r [N+1];
  logic          pal_r [N+1];

  always_comb begin
    vld_r[0] = in_vld;
    rem_r[0] = in_num;
    den_r[0] = in_den;
    quo_r[0] = '0;
    pal_r[0] = in_pal;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int SH = N - 1 - s;
    logic [NW:0] trial;
    logic        fits;
    assign trial = {1'b0, rem_r[s]} - ({{(NW+1-DW){1'b0}}, den_r[s]} << SH);
    assign fits  = ~trial[NW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= fits ? trial[NW-1:0] : rem_r[s];
        den_r[s+1] <= den_r[s];
        quo_r[s+1] <= quo_r[s] | (N'(fits) << SH);
        pal_r[s+1] <= pal_r[s];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_quo = quo_r[N];
  assign out_pal = pal_r[N];
endmodule
`default_nettype wire

[sv/thermal_false_color_mapper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Thermal false-color mapper
// Maps signed fixed-point temperature samples to iron or rainbow RGB pixels.
// ---------------------------------------------------------------------------
// Usage: samples arrive on the temp channel, one beat per sample, and one
// RGB pixel beat leaves on the pixel channel for each, in order. The cfg
// port writes low_bound, high_bound and palette_select; write only while
// the pipeline is empty. Reset clears all three registers and every valid
// bit.
// The pipeline has 13 register stages: one stage clamps, one forms the
// numerator, ten restoring divider stages each settle one index bit, and
// the output register takes the color mapped from the index. Throughput is
// one pixel per cycle while the receiver takes pixels; the divider stage
// count sets the latency. When the receiver stalls, the whole pipeline
// holds, and input ready drops only when the output register is full and
// not being taken.
// ---------------------------------------------------------------------------
module thermal_false_color_mapper (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  tfcm_temp_if.sink                                in_ch,
  tfcm_rgb_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [tfcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tfcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int BW = tfcm_pkg::BOUND_W;
  localparam int NW = tfcm_pkg::NUM_W;
  localparam int DW = tfcm_pkg::DEN_W;
  localparam int IW = tfcm_pkg::IDX_W;

  // Configuration registers.
  logic [BW-1:0] low_bound_r, high_bound_r;
  logic          palette_select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r      <= '0;
      high_bound_r     <= '0;
      palette_select_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tfcm_pkg::REG_LOW_BOUND:      low_bound_r      <= cfg_data[BW-1:0];
        tfcm_pkg::REG_HIGH_BOUND:     high_bound_r     <= cfg_data[BW-1:0];
        tfcm_pkg::REG_PALETTE_SELECT: palette_select_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bounds limited to the top temperature.
  logic [BW-1:0] lo, hi;
  assign lo = (low_bound_r  > BW'(tfcm_pkg::BOUND_TOP)) ? BW'(tfcm_pkg::BOUND_TOP)
                                                        : low_bound_r;
  assign hi = (high_bound_r > BW'(tfcm_pkg::BOUND_TOP)) ? BW'(tfcm_pkg::BOUND_TOP)
                                                        : high_bound_r;

  // Pipeline advances whenever the output register can take a new pixel.
  logic out_vld_r;
  logic adv;
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: clamp and offset.
  logic          s1_vld_r, s1_pal_r, s1_zero_r;
  logic [BW-1:0] s1_d_r, s1_span_r;
  logic signed [tfcm_pkg::TEMP_W:0] t_ext;
  logic [BW-1:0] t_cl;
  assign t_ext = {in_ch.temp_in[tfcm_pkg::TEMP_W-1], in_ch.temp_in};

  always_comb begin
    if (t_ext < $signed({6'd0, lo})) t_cl = lo;
    else if (t_ext > $signed({6'd0, hi})) t_cl = hi;
    else t_cl = t_ext[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pal_r  <= palette_select_r;
      s1_zero_r <= (hi <= lo);
      s1_d_r    <= t_cl - lo;
      s1_span_r <= hi - lo;
    end
  end

  // Stage 2: numerator 2*d*(S-1)+span and denominator 2*span.
  logic          s2_vld_r, s2_pal_r;
  logic [NW-1:0] s2_num_r;
  logic [DW-1:0] s2_den_r;
  logic [IW-1:0] size_m1;
  assign size_m1 = s1_pal_r ? IW'(tfcm_pkg::RAINBOW_SIZE - 1)
                            : IW'(tfcm_pkg::IRON_SIZE - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pal_r <= s1_pal_r;
      // A zero numerator and unit divisor give index zero.
      s2_num_r <= s1_zero_r ? '0
                : ((NW'(s1_d_r) * NW'(size_m1)) << 1) + NW'(s1_span_r);
      s2_den_r <= s1_zero_r ? DW'(1) : {s1_span_r, 1'b0};
    end
  end

  // Divider stages.
  logic          dv_vld, dv_pal;
  logic [IW-1:0] dv_quo;

  tfcm_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (s2_vld_r),
    .in_num (s2_num_r),
    .in_den (s2_den_r),
    .in_pal (s2_pal_r),
    .out_vld(dv_vld),
    .out_quo(dv_quo),
    .out_pal(dv_pal)
  );

  // Color stage.
  tfcm_pkg::rgb_t iron_c, rain_c, pix_nxt;
  logic [1:0]     ramp;
  logic [IW-1:0]  v_full;
  tfcm_pkg::color_t v;

  always_comb begin
    iron_c = tfcm_pkg::iron_lookup(7'(dv_quo));
    if (dv_quo <= IW'(255))      ramp = 2'd0;
    else if (dv_quo <= IW'(510)) ramp = 2'd1;
    else if (dv_quo <= IW'(765)) ramp = 2'd2;
    else                         ramp = 2'd3;
    v_full = dv_quo - IW'(ramp) * IW'(tfcm_pkg::RAMP_WIDTH);
    v      = v_full[7:0];
    case (ramp)
      2'd0:    rain_c = '{8'd0, v, 8'd255};
      2'd1:    rain_c = '{8'd0, 8'd255, 8'd255 - v};
      2'd2:    rain_c = '{v, 8'd255, 8'd0};
      default: rain_c = '{8'd255, 8'd255 - v, 8'd0};
    endcase
    pix_nxt = (dv_pal == tfcm_pkg::PAL_RAINBOW) ? rain_c : iron_c;
  end

  tfcm_pkg::rgb_t pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.red   = pix_r.red;
  assign out_ch.green = pix_r.green;
  assign out_ch.blue  = pix_r.blue;

  // Assertions.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(pix_r))
    else $error("pixel changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_vld_r || out_ch.ready))
    else $error("input ready does not follow output space");
  a_s1_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("accepted beat lost at first stage");
  a_iron_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld && dv_pal == tfcm_pkg::PAL_IRON |-> dv_quo < IW'(tfcm_pkg::IRON_SIZE))
    else $error("iron index out of range");
endmodule
`default_nettype wire

[tb/thermal_false_color_mapper_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thermal false-color mapper testbench
// Streams temperature samples through the mapper under several bound and
// palette settings and checks every RGB pixel against an in-bench color
// predictor, with random gaps, random and long back-pressure on the pixel
// side, and register writes only while the pipeline is drained.
// ---------------------------------------------------------------------------
module thermal_false_color_mapper_tb;

  localparam int TW = tfcm_pkg::TEMP_W;
  localparam int CW = tfcm_pkg::CFG_DATA_W;
  localparam int XW = tfcm_pkg::CFG_IDX_W;
  localparam logic [tfcm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 600000;

  // Iron palette entries, {red, green, blue}.
  localparam tfcm_pkg::rgb_t IRON_PAL [tfcm_pkg::IRON_SIZE] = '{
    '{0,0,0},'{0,0,36},'{0,0,51},'{0,0,66},'{0,0,81},'{2,0,90},'{4,0,99},'{7,0,106},
    '{11,0,115},'{14,0,119},'{20,0,123},'{27,0,128},'{33,0,133},'{41,0,137},
    '{48,0,140},'{55,0,143},'{61,0,146},'{66,0,149},'{72,0,150},'{78,0,151},
    '{84,0,152},'{91,0,153},'{97,0,155},'{104,0,155},'{110,0,156},'{115,0,157},
    '{122,0,157},'{128,0,157},'{134,0,157},'{139,0,157},'{146,0,156},'{152,0,155},
    '{157,0,155},'{162,0,155},'{167,0,154},'{171,0,153},'{175,1,152},'{178,1,151},
    '{182,2,149},'{185,4,149},'{188,5,147},'{191,6,146},'{193,8,144},'{195,11,142},
    '{198,13,139},'{201,17,135},'{203,20,132},'{206,23,127},'{208,26,121},
    '{210,29,116},'{212,33,111},'{214,37,103},'{217,41,97},'{219,46,89},
    '{221,49,78},'{223,53,66},'{224,56,54},'{226,60,42},'{228,64,30},'{229,68,25},
    '{231,72,20},'{232,76,16},'{234,78,12},'{235,82,10},'{236,86,8},'{237,90,7},
    '{238,93,5},'{239,96,4},'{240,100,3},'{241,103,3},'{241,106,2},'{242,109,1},
    '{243,113,1},'{244,116,0},'{244,120,0},'{245,125,0},'{246,129,0},'{247,133,0},
    '{248,136,0},'{248,139,0},'{249,142,0},'{249,145,0},'{250,149,0},'{251,154,0},
    '{252,159,0},'{253,163,0},'{253,168,0},'{253,172,0},'{254,176,0},'{254,179,0},
    '{254,184,0},'{254,187,0},'{254,191,0},'{254,195,0},'{254,199,0},'{254,202,1},
    '{254,205,2},'{254,208,5},'{254,212,9},'{254,216,12},'{255,219,15},
    '{255,221,23},'{255,224,32},'{255,227,39},'{255,229,50},'{255,232,63},
    '{255,235,75},'{255,238,88},'{255,239,102},'{255,241,116},'{255,242,134},
    '{255,244,149},'{255,245,164},'{255,247,179},'{255,248,192},'{255,249,203},
    '{255,251,216},'{255,253,228},'{255,254,239}
  };

  // Tracks the register copy and the pixels still owed by the mapper.
  class pixel_tracker;
    logic [tfcm_pkg::BOUND_W-1:0] low_reg;
    logic [tfcm_pkg::BOUND_W-1:0] high_reg;
    logic                         pal_reg;
    tfcm_pkg::rgb_t               owed[$];
    int                           errors;

    function new();
      low_reg = '0;
      high_reg = '0;
      pal_reg = tfcm_pkg::PAL_IRON;
      errors = 0;
    endfunction

    function void write_reg(logic [XW-1:0] idx, logic [CW-1:0] val);
      case (idx)
        tfcm_pkg::REG_LOW_BOUND:      low_reg = val;
        tfcm_pkg::REG_HIGH_BOUND:     high_reg = val;
        tfcm_pkg::REG_PALETTE_SELECT: pal_reg = val[0];
        default: ;
      endcase
    endfunction

    // Clamped, scaled palette index, rounded half up.
    function int scaled_index(longint t, int size);
      longint lo, hi, d, span;
      lo = (low_reg > tfcm_pkg::BOUND_TOP) ? tfcm_pkg::BOUND_TOP : low_reg;
      hi = (high_reg > tfcm_pkg::BOUND_TOP) ? tfcm_pkg::BOUND_TOP : high_reg;
      if (hi <= lo) return 0;
      if (t < lo) t = lo;
      else if (t > hi) t = hi;
      d = t - lo;
      span = hi - lo;
      return int'((2 * d * (size - 1) + span) / (2 * span));
    endfunction

    function tfcm_pkg::rgb_t map_temp(logic signed [TW-1:0] temp);
      tfcm_pkg::rgb_t c;
      int   n, ramp, v;
      if (pal_reg == tfcm_pkg::PAL_IRON) begin
        n = scaled_index(temp, tfcm_pkg::IRON_SIZE);
        if (n >= tfcm_pkg::IRON_SIZE) n = tfcm_pkg::IRON_SIZE - 1;
        c = IRON_PAL[n];
      end else begin
        n = scaled_index(temp, tfcm_pkg::RAINBOW_SIZE);
        ramp = (n == 0) ? 0 : (n - 1) / tfcm_pkg::RAMP_WIDTH;
        if (ramp > 3) ramp = 3;
        v = n - ramp * tfcm_pkg::RAMP_WIDTH;
        if (v > 255) v = 255;
        case (ramp)
          0:       c = '{8'd0, tfcm_pkg::color_t'(v), 8'd255};
          1:       c = '{8'd0, 8'd255, tfcm_pkg::color_t'(255 - v)};
          2:       c = '{tfcm_pkg::color_t'(v), 8'd255, 8'd0};
          default: c = '{8'd255, tfcm_pkg::color_t'(255 - v), 8'd0};
        endcase
      end
      return c;
    endfunction

    function void note_sample(logic signed [TW-1:0] temp);
      owed.push_back(map_temp(temp));
    endfunction

    function void check_pixel(tfcm_pkg::rgb_t got);
      tfcm_pkg::rgb_t exp_c;
      if (owed.size() == 0) begin
        $error("unexpected pixel beat r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      exp_c = owed.pop_front();
      if (got.red !== exp_c.red) begin
        $error("red: expected %0d, got %0d", exp_c.red, got.red);
        errors++;
      end
      if (got.green !== exp_c.green) begin
        $error("green: expected %0d, got %0d", exp_c.green, got.green);
        errors++;
      end
      if (got.blue !== exp_c.blue) begin
        $error("blue: expected %0d, got %0d", exp_c.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [XW-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  int   cycles;
  int   stall_request;

  tfcm_temp_if in_ch ();
  tfcm_rgb_if  out_ch ();
  pixel_tracker tracker = new();

  thermal_false_color_mapper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Pixel receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_request > 0) begin
      out_ch.ready <= 1'b0;
      stall_request = stall_request - 1;
    end else begin
      n = $urandom_range(99);
      out_ch.ready <= (n >= 25);
      if (n == 0) stall_request = $urandom_range(30, 5);
    end
  end

  // Beat monitor on both channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.note_sample(in_ch.temp_in);
      if (out_ch.valid && out_ch.ready)
        tracker.check_pixel('{out_ch.red, out_ch.green, out_ch.blue});
    end
  end

  // Stop offering samples and wait until every owed pixel has come.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [XW-1:0] idx, logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_mapping(int lo, int hi, logic pal);
    wait_drained();
    write_reg(tfcm_pkg::REG_LOW_BOUND, lo[CW-1:0]);
    write_reg(tfcm_pkg::REG_HIGH_BOUND, hi[CW-1:0]);
    write_reg(tfcm_pkg::REG_PALETTE_SELECT, {{(CW-1){1'b0}}, pal});
    cfg_we <= 1'b0;
  endtask

  // One sample beat; valid stays up across back-to-back beats.
  task automatic send_sample(logic signed [TW-1:0] temp, bit gaps);
    int g;
    in_ch.valid   <= 1'b1;
    in_ch.temp_in <= temp;
    do @(posedge clk); while (!in_ch.ready);
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Random sample, mostly near the active bounds, sometimes anywhere.
  function automatic logic signed [TW-1:0] random_temp();
    int lo, hi;
    lo = (tracker.low_reg > tfcm_pkg::BOUND_TOP) ? tfcm_pkg::BOUND_TOP : tracker.low_reg;
    hi = (tracker.high_reg > tfcm_pkg::BOUND_TOP) ? tfcm_pkg::BOUND_TOP : tracker.high_reg;
    if (hi < lo) begin
      lo = hi;
      hi = tracker.low_reg;
    end
    if ($urandom_range(99) < 20) return TW'($urandom());
    return TW'($urandom_range(hi + 64, lo) - 32);
  endfunction

  initial begin
    int lo, hi;
    logic signed [TW-1:0] edges[$];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.temp_in = '0;
    cycles        = 0;
    stall_request = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset bounds are equal: index 0 whatever the sample.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);

    // Full range, both palettes, at the field and bound extremes.
    edges = '{-16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, 16'sd639, 16'sd640,
              16'sd641, 16'sd1279, 16'sd1280, 16'sd1281};
    set_mapping(0, tfcm_pkg::BOUND_TOP, tfcm_pkg::PAL_IRON);
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    set_mapping(0, tfcm_pkg::BOUND_TOP, tfcm_pkg::PAL_RAINBOW);
    foreach (edges[i]) send_sample(edges[i], 1'b0);
    // Bounds above the 80 degree limit, then high below low.
    set_mapping(2047, 2047, tfcm_pkg::PAL_RAINBOW);
    send_sample(16'sd1280, 1'b0);
    set_mapping(tfcm_pkg::BOUND_TOP, 0, tfcm_pkg::PAL_RAINBOW);
    send_sample(16'sd500, 1'b0);
    // A write to an unused index must change nothing.
    wait_drained();
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_sample(16'sd500, 1'b0);

    // Random phases, with fixed corner settings among them.
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: set_mapping(0, 1, tfcm_pkg::PAL_RAINBOW);
        1: set_mapping(1279, 2047, tfcm_pkg::PAL_IRON);
        2: set_mapping(0, 2047, tfcm_pkg::PAL_IRON);
        3: set_mapping(300, 300, tfcm_pkg::PAL_IRON);
        default: begin
          lo = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(1280);
          hi = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(1280);
          set_mapping(lo, hi, 1'($urandom_range(1)));
        end
      endcase
      if (phase == 5) stall_request = 400;
      for (int k = 0; k < 86; k++) send_sample(random_temp(), phase != 6);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end

    wait_drained();
    if (tracker.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
sv/tfcm_pkg.sv
sv/tfcm_if.sv
sv/tfcm_divider.sv
sv/thermal_false_color_mapper.sv
tb/thermal_false_color_mapper_tb.sv
